// ===== sv/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg: shared types and constants for the moving-average crossover block
// Field widths, stream word layout and the direction codes.
// ----------------------------------------------------------------------------
package mac_pkg;

    // field widths
    localparam int SEQ_W   = 32;
    localparam int PRICE_W = 24;
    localparam int TS_W    = 32;

    // input word: seq_number, price, timestamp (88 bits, whole bytes)
    localparam int IN_TDATA_W = 88;

    // output word: order_seq, direction, order_price, order_timestamp (89 bits)
    localparam int OUT_USED_W  = SEQ_W + 1 + PRICE_W + TS_W;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = FIFO_AW + 1;

    // last emitted direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_BUY  = 2'b01,
        DIR_SELL = 2'b10
    } dir_t;

    // one queued result
    typedef struct packed {
        logic [TS_W-1:0]    order_timestamp;
        logic [PRICE_W-1:0] order_price;
        logic               direction;
        logic [SEQ_W-1:0]   order_seq;
    } order_t;

endpackage

// ===== sv/moving_average_crossover.sv =====
// ----------------------------------------------------------------------------
// moving_average_crossover: short/long simple moving average crossover
//
// Usage:
//   s_axis carries one price word per handshake: seq_number [31:0],
//   price [55:32], timestamp [87:56]. m_axis carries one order word each
//   time the crossover direction changes: order_seq [31:0], direction [32]
//   (1 buy, 0 sell), order_price [56:33], order_timestamp [88:57].
//   Nothing comes out until LONG_LEN prices have been taken; after that the
//   first decision always comes out.
//   Throughput: one word per cycle while s_axis_tready stays high. The price
//   history sits in a LONG_LEN-entry memory written at the accept edge and
//   read at the same edge (oldest entry and the entry SHORT_LEN back); running
//   sums are updated in the following cycle.
//   Path to m_axis_tvalid: memory read, sum update, reciprocal multiply,
//   then direction compare and a write into the result queue.
//   Reset: fill count, write slot, sums and last direction clear at once;
//   the history memory is not cleared and needs no clearing pass.
//   Stall: results wait in an 8-entry queue; s_axis_tready drops only when
//   queued plus in-flight results fill it.
// ----------------------------------------------------------------------------
module moving_average_crossover #(
    parameter int SHORT_LEN = 4,
    parameter int LONG_LEN  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input word: seq_number[31:0], price[55:32], timestamp[87:56]
    input  logic [mac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // output word: order_seq[31:0], direction[32], order_price[56:33],
    // order_timestamp[88:57], zero pad above
    output logic [mac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);

    localparam int PW        = mac_pkg::PRICE_W;
    localparam int ADDR_W    = $clog2(LONG_LEN);
    localparam int FILL_W    = $clog2(LONG_LEN + 1);
    localparam int SHORT_EFF = (SHORT_LEN < LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int LSUM_W    = PW + $clog2(LONG_LEN);
    localparam int SSUM_W    = PW + $clog2(SHORT_EFF);
    localparam int L_SHIFT   = LSUM_W + $clog2(LONG_LEN);
    localparam int S_SHIFT   = SSUM_W + $clog2(SHORT_LEN);
    localparam int L_PROD_W  = 2 * LSUM_W + 1;
    localparam int S_PROD_W  = 2 * SSUM_W + 1;
    localparam logic [63:0] L_RECIP_FULL =
        ((64'd1 << L_SHIFT) + 64'(LONG_LEN) - 64'd1) / 64'(LONG_LEN);
    localparam logic [63:0] S_RECIP_FULL =
        ((64'd1 << S_SHIFT) + 64'(SHORT_LEN) - 64'd1) / 64'(SHORT_LEN);
    localparam logic [LSUM_W:0] L_RECIP = L_RECIP_FULL[LSUM_W:0];
    localparam logic [SSUM_W:0] S_RECIP = S_RECIP_FULL[SSUM_W:0];

    // input word unpack
    logic                         in_acc;
    logic [mac_pkg::SEQ_W-1:0]    seq_in;
    logic [PW-1:0]                price_in;
    logic [mac_pkg::TS_W-1:0]     ts_in;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign seq_in   = s_axis_tdata[31:0];
    assign price_in = s_axis_tdata[55:32];
    assign ts_in    = s_axis_tdata[87:56];

    // write slot and fill count
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [ADDR_W:0]   short_sum_addr;
    logic [ADDR_W-1:0] short_addr;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (in_acc)
        begin
            if (wr_ptr_reg == ADDR_W'(LONG_LEN - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
            if (fill_reg != FILL_W'(LONG_LEN))
                fill_next = fill_reg + 1'b1;
        end
    end

    // slot written SHORT_EFF words ago (modulo LONG_LEN)
    always_comb
    begin
        short_sum_addr = {1'b0, wr_ptr_reg} + (ADDR_W + 1)'(LONG_LEN - SHORT_EFF);
        if (short_sum_addr >= (ADDR_W + 1)'(LONG_LEN))
            short_sum_addr = short_sum_addr - (ADDR_W + 1)'(LONG_LEN);
        short_addr = short_sum_addr[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // price history: write new price, read evicted and short-window tail
    logic [PW-1:0] hist_mem [LONG_LEN];
    logic [PW-1:0] evict_rd_reg;
    logic [PW-1:0] short_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hist_mem[wr_ptr_reg] <= price_in;
            evict_rd_reg         <= hist_mem[wr_ptr_reg];
            short_rd_reg         <= hist_mem[short_addr];
        end
    end

    // stage 1: word after memory read
    logic                      s1_valid_reg;
    logic                      s1_decide_reg;
    logic                      s1_long_full_reg;
    logic                      s1_short_full_reg;
    logic [mac_pkg::SEQ_W-1:0] s1_seq_reg;
    logic [PW-1:0]             s1_price_reg;
    logic [mac_pkg::TS_W-1:0]  s1_ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s1_decide_reg     <= 1'b0;
            s1_long_full_reg  <= 1'b0;
            s1_short_full_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= in_acc;
            s1_decide_reg     <= in_acc && (fill_next == FILL_W'(LONG_LEN));
            s1_long_full_reg  <= (fill_reg == FILL_W'(LONG_LEN));
            s1_short_full_reg <= (fill_reg >= FILL_W'(SHORT_EFF));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_seq_reg   <= seq_in;
            s1_price_reg <= price_in;
            s1_ts_reg    <= ts_in;
        end
    end

    // running sums: add newest, drop the one leaving each window
    logic [LSUM_W-1:0] long_sum_reg, long_sum_next;
    logic [SSUM_W-1:0] short_sum_reg, short_sum_next;

    always_comb
    begin
        long_sum_next  = long_sum_reg;
        short_sum_next = short_sum_reg;
        if (s1_valid_reg)
        begin
            long_sum_next = long_sum_reg + LSUM_W'(s1_price_reg)
                          - (s1_long_full_reg ? LSUM_W'(evict_rd_reg) : '0);
            short_sum_next = short_sum_reg + SSUM_W'(s1_price_reg)
                           - (s1_short_full_reg ? SSUM_W'(short_rd_reg) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_sum_reg  <= '0;
            short_sum_reg <= '0;
        end
        else
        begin
            long_sum_reg  <= long_sum_next;
            short_sum_reg <= short_sum_next;
        end
    end

    // stage 2: sums valid for a deciding word
    logic                      s2_valid_reg;
    logic [mac_pkg::SEQ_W-1:0] s2_seq_reg;
    logic [PW-1:0]             s2_price_reg;
    logic [mac_pkg::TS_W-1:0]  s2_ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_decide_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_seq_reg   <= s1_seq_reg;
            s2_price_reg <= s1_price_reg;
            s2_ts_reg    <= s1_ts_reg;
        end
    end

    // stage 3: floor averages by reciprocal multiply
    logic [L_PROD_W-1:0]       long_prod;
    logic [S_PROD_W-1:0]       short_prod;
    logic                      s3_valid_reg;
    logic [PW-1:0]             q_long_reg;
    logic [PW-1:0]             q_short_reg;
    logic [mac_pkg::SEQ_W-1:0] s3_seq_reg;
    logic [PW-1:0]             s3_price_reg;
    logic [mac_pkg::TS_W-1:0]  s3_ts_reg;

    assign long_prod  = L_PROD_W'(long_sum_reg) * L_PROD_W'(L_RECIP);
    assign short_prod = S_PROD_W'(short_sum_reg) * S_PROD_W'(S_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            q_long_reg   <= PW'(long_prod >> L_SHIFT);
            q_short_reg  <= PW'(short_prod >> S_SHIFT);
            s3_seq_reg   <= s2_seq_reg;
            s3_price_reg <= s2_price_reg;
            s3_ts_reg    <= s2_ts_reg;
        end
    end

    // stage 4: direction, emit on change
    mac_pkg::dir_t   prev_dir_reg;
    mac_pkg::dir_t   new_dir;
    logic            push;
    mac_pkg::order_t push_word;

    assign new_dir = (q_short_reg > q_long_reg) ? mac_pkg::DIR_BUY : mac_pkg::DIR_SELL;
    assign push    = s3_valid_reg && (new_dir != prev_dir_reg);

    always_comb
    begin
        push_word.order_seq       = s3_seq_reg;
        push_word.direction       = (new_dir == mac_pkg::DIR_BUY);
        push_word.order_price     = s3_price_reg;
        push_word.order_timestamp = s3_ts_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_dir_reg <= mac_pkg::DIR_NONE;
        else if (push)
            prev_dir_reg <= new_dir;
    end

    // result queue
    mac_pkg::order_t             fifo_mem [mac_pkg::FIFO_DEPTH];
    logic [mac_pkg::FIFO_AW-1:0] fifo_wr_reg;
    logic [mac_pkg::FIFO_AW-1:0] fifo_rd_reg;
    logic [mac_pkg::FIFO_CW-1:0] fifo_count_reg;
    logic                        pop;
    mac_pkg::order_t             head;
    logic [1:0]                  inflight;
    logic [mac_pkg::FIFO_CW:0]   reserved;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_mem[fifo_rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[fifo_wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_reg    <= '0;
            fifo_rd_reg    <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (push)
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            if (pop)
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            case ({push, pop})
                2'b10:   fifo_count_reg <= fifo_count_reg + 1'b1;
                2'b01:   fifo_count_reg <= fifo_count_reg - 1'b1;
                default: fifo_count_reg <= fifo_count_reg;
            endcase
        end
    end

    // input ready: room for every word that may still produce a result
    assign inflight = 2'(s1_valid_reg && s1_decide_reg) + 2'(s2_valid_reg)
                    + 2'(s3_valid_reg);
    assign reserved = (mac_pkg::FIFO_CW + 1)'(fifo_count_reg)
                    + (mac_pkg::FIFO_CW + 1)'(inflight);
    assign s_axis_tready = (reserved < (mac_pkg::FIFO_CW + 1)'(mac_pkg::FIFO_DEPTH));

    // output word
    assign m_axis_tvalid = (fifo_count_reg != '0);
    assign m_axis_tdata  = {{mac_pkg::OUT_PAD_W{1'b0}}, head.order_timestamp,
                            head.order_price, head.direction, head.order_seq};

    // assertions
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count_reg != mac_pkg::FIFO_CW'(mac_pkg::FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved <= (mac_pkg::FIFO_CW + 1)'(mac_pkg::FIFO_DEPTH))
        else $error("queued plus in-flight results exceed queue depth");

    a_no_output_in_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (fill_reg == FILL_W'(LONG_LEN)))
        else $error("result before history filled");

    a_fill_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_W'(LONG_LEN)) |=> (fill_reg == FILL_W'(LONG_LEN)))
        else $error("fill count left saturation");

    a_push_changes_dir: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (prev_dir_reg != mac_pkg::DIR_NONE) && !$stable(prev_dir_reg))
        else $error("emitted word did not change direction");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for moving_average_crossover
// Feeds price words from a pending queue with random gaps, forecasts every
// crossover order in a behavioral copy of the averaging logic, and compares
// each order word from the block with the oldest forecast, field by field.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHORT_LEN   = 4;
    localparam int LONG_LEN    = 16;
    localparam int RANDOM_TICKS = 800;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [23:0] PRICE_MAX = 24'hFF_FFFF;

    // one price sample plus the idle cycles to wait before offering it
    typedef struct {
        logic [31:0] seq;
        logic [23:0] price;
        logic [31:0] stamp;
        int unsigned gap;
    } tick_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [mac_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [mac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;

    tick_t              pending_ticks[$];
    mac_pkg::order_t    expected_orders[$];
    tick_t              tick_on_bus;
    int unsigned        gap_count;
    int unsigned        stall_left;
    bit                 rx_no_stall;
    int unsigned        error_count;
    int unsigned        cycle_count;

    // forecast state of the crossover detector
    logic [23:0]        price_hist[LONG_LEN];
    int unsigned        hist_slot;
    int unsigned        samples_seen;
    mac_pkg::dir_t      prev_dir;

    moving_average_crossover #(
        .SHORT_LEN (SHORT_LEN),
        .LONG_LEN  (LONG_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // store the sample, update the windows, queue an order on a direction change
    task automatic forecast_order(input tick_t t);
        logic [63:0]     long_acc;
        logic [63:0]     short_acc;
        int unsigned     newest;
        int unsigned     idx;
        mac_pkg::dir_t   dir;
        mac_pkg::order_t ord;
        begin
            newest = hist_slot;
            price_hist[newest] = t.price;
            hist_slot = (newest + 1) % LONG_LEN;
            if (samples_seen < LONG_LEN)
                samples_seen++;
            if (samples_seen < LONG_LEN)
                return;
            long_acc  = '0;
            short_acc = '0;
            for (int i = 0; i < LONG_LEN; i++)
            begin
                idx = (newest + LONG_LEN - i) % LONG_LEN;
                long_acc += price_hist[idx];
                if (i < SHORT_LEN)
                    short_acc += price_hist[idx];
            end
            // equal averages count as sell
            dir = (short_acc / SHORT_LEN > long_acc / LONG_LEN) ? mac_pkg::DIR_BUY
                                                                : mac_pkg::DIR_SELL;
            if (dir == prev_dir)
                return;
            prev_dir = dir;
            ord.order_seq       = t.seq;
            ord.direction       = (dir == mac_pkg::DIR_BUY);
            ord.order_price     = t.price;
            ord.order_timestamp = t.stamp;
            expected_orders.push_back(ord);
        end
    endtask

    task automatic add_tick(input logic [31:0] seq, input logic [23:0] price,
                            input logic [31:0] stamp, input int unsigned gap);
        tick_t t;
        begin
            t.seq   = seq;
            t.price = price;
            t.stamp = stamp;
            t.gap   = gap;
            pending_ticks.push_back(t);
        end
    endtask

    // sender: offer words from the pending queue, forecast each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_count     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                forecast_order(tick_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (gap_count < pending_ticks[0].gap)
                begin
                    gap_count     <= gap_count + 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    tick_on_bus    = pending_ticks.pop_front();
                    gap_count     <= 0;
                    s_axis_tdata  <= {tick_on_bus.stamp, tick_on_bus.price, tick_on_bus.seq};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver: random stall per order word, compare with the oldest forecast
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            rx_no_stall   <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            mac_pkg::order_t got;
            mac_pkg::order_t want;
            int unsigned     w;
            got = mac_pkg::order_t'(m_axis_tdata[mac_pkg::OUT_USED_W-1:0]);
            if (expected_orders.size() == 0)
            begin
                $error("unexpected order word %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_orders.pop_front();
                if (got.order_seq !== want.order_seq)
                begin
                    $error("order_seq: expected %h, got %h", want.order_seq, got.order_seq);
                    error_count++;
                end
                if (got.direction !== want.direction)
                begin
                    $error("direction: expected %b, got %b", want.direction, got.direction);
                    error_count++;
                end
                if (got.order_price !== want.order_price)
                begin
                    $error("order_price: expected %h, got %h",
                           want.order_price, got.order_price);
                    error_count++;
                end
                if (got.order_timestamp !== want.order_timestamp)
                begin
                    $error("order_timestamp: expected %h, got %h",
                           want.order_timestamp, got.order_timestamp);
                    error_count++;
                end
                if (m_axis_tdata[mac_pkg::OUT_TDATA_W-1:mac_pkg::OUT_USED_W] !== '0)
                begin
                    $error("pad: expected 0, got %h",
                           m_axis_tdata[mac_pkg::OUT_TDATA_W-1:mac_pkg::OUT_USED_W]);
                    error_count++;
                end
            end
            // switch between stalling and free-running stretches now and then
            if ($urandom_range(0, 24) == 0)
                rx_no_stall <= !rx_no_stall;
            w = rx_no_stall ? 0 : $urandom_range(0, 6);
            stall_left    <= w;
            m_axis_tready <= (w == 0);
        end
        else if (m_axis_tvalid)
        begin
            // count the stall down only while a word is waiting
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left <= 1);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("moving_average_crossover regression: fail");
            $finish;
        end
    end

    initial
    begin
        int          px;
        int          step;
        int          seg_len;
        int          mode;
        int unsigned made;
        bit          tx_no_gap;

        error_count  = 0;
        cycle_count  = 0;
        hist_slot    = 0;
        samples_seen = 0;
        prev_dir     = mac_pkg::DIR_NONE;

        // warm-up at full-scale price: widest sums, equal averages give sell
        add_tick(32'h0000_0000, PRICE_MAX, 32'h0000_0000, 0);
        for (int i = 1; i < LONG_LEN - 1; i++)
            add_tick(i, PRICE_MAX, $urandom, $urandom_range(0, 2));
        add_tick(32'hFFFF_FFFF, PRICE_MAX, 32'hFFFF_FFFF, 0);
        // drop to zero: still sell, no order
        for (int i = 0; i < 3; i++)
            add_tick(32'hFFFF_FFFF - i, 24'h00_0000, 32'h0000_0000, 0);
        // back to full scale: short window climbs above, buy
        for (int i = 0; i < 4; i++)
            add_tick(32'h8000_0000 + i, PRICE_MAX, 32'hFFFF_FFFF, 0);

        // random segments of trends, noise, flats and extremes
        made = 0;
        px   = $urandom_range(0, PRICE_MAX);
        while (made < RANDOM_TICKS)
        begin
            seg_len   = $urandom_range(4, 40);
            mode      = $urandom_range(0, 5);
            tx_no_gap = ($urandom_range(0, 2) == 0);
            step      = 1 << $urandom_range(0, 20);
            if ($urandom_range(0, 1) == 1)
                step = -step;
            for (int k = 0; k < seg_len; k++)
            begin
                case (mode) inside
                    [0:2]: px = px + step + $signed($urandom_range(0, 2 * (step < 0 ?
                                -step : step))) - (step < 0 ? -step : step);
                    3: px = $urandom_range(0, PRICE_MAX);
                    4: ;
                    default: px = ($urandom_range(0, 1) == 1) ?
                                  PRICE_MAX - $urandom_range(0, 3) : $urandom_range(0, 3);
                endcase
                if (px < 0)
                    px = 0;
                if (px > PRICE_MAX)
                    px = PRICE_MAX;
                add_tick($urandom, px[23:0], $urandom,
                         tx_no_gap ? 0 : $urandom_range(0, 6));
                made++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all words to go in and all forecast orders to come out
        while (pending_ticks.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_orders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("moving_average_crossover regression: pass");
        else
            $display("moving_average_crossover regression: fail");
        $finish;
    end

endmodule
